// ===== hdl/gtp_pkg.sv =====
// shared types and constants for the gaussian / top-hat density pipeline
package gtp_pkg;

	// restoring divider depths, one quotient bit per stage
	localparam int DIV1_STEPS = 32;
	localparam int DIV2_STEPS = 39;

	// series length of the exponential
	localparam int TERMS = 14;

	// fixed-point constants
	localparam logic [32:0] LOG2E        = 33'd6196328019;
	localparam logic [31:0] LN2          = 32'd2977044472;
	localparam logic [30:0] INV_SQRT_2PI = 31'd1713444047;
	localparam logic [31:0] ONE_Q24      = 32'h0100_0000;
	localparam logic [31:0] DENSITY_MAX  = 32'hFFFF_FFFF;

	typedef enum logic {
		CMD_TOPHAT   = 1'b0,
		CMD_GAUSSIAN = 1'b1
	} cmd_t;

	typedef struct packed {
		logic               command;
		logic signed [31:0] center;
		logic        [30:0] spread;
		logic signed [31:0] sample;
	} req_t;

	typedef struct packed {
		logic [31:0] density;
		logic        bad_width;
	} rsp_t;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic        gauss;
		logic        bad;
		logic        hit;
		logic        far;
		logic [30:0] spread;
		logic [6:0]  shift;
	} side_t;

endpackage

// ===== hdl/gtp_exp.sv =====
// pipelined series evaluation of e^-y, three stages per term after the first
module gtp_exp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  gtp_pkg::side_t     in_side,
	input  logic [31:0]        y,
	output logic               out_valid,
	output gtp_pkg::side_t     out_side,
	output logic signed [34:0] sum
);
	import gtp_pkg::*;

	localparam int STEPS = TERMS - 1;

	typedef struct packed {
		side_t              side;
		logic [31:0]        y;
		logic [31:0]        term;
		logic signed [34:0] acc;
		logic [63:0]        prod;
	} tay_t;

	tay_t head_n;
	tay_t head_s;
	logic head_v_s;
	tay_t ta_s [STEPS];
	tay_t tb_s [STEPS];
	tay_t tc_s [STEPS];
	logic va_s [STEPS];
	logic vb_s [STEPS];
	logic vc_s [STEPS];

	// first term: 1 - y
	always_comb begin
		head_n      = '0;
		head_n.side = in_side;
		head_n.y    = y;
		head_n.term = y;
		head_n.acc  = $signed(35'h1_0000_0000 - {3'b000, y});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_s <= 1'b0;
		end else if (en) begin
			head_v_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s <= head_n;
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_term
		localparam logic [3:0]  DIVISOR = 4'(g + 2);
		localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / (g + 2));
		localparam bit          ODD     = ((g + 2) % 2) == 1;

		tay_t        prev;
		logic        prev_v;
		tay_t        a_n;
		tay_t        b_n;
		tay_t        c_n;
		logic [31:0] q0;
		logic [31:0] rem;
		logic [31:0] qt;

		if (g == 0) begin : g_first
			assign prev   = head_s;
			assign prev_v = head_v_s;
		end else begin : g_next
			assign prev   = tc_s[g-1];
			assign prev_v = vc_s[g-1];
		end

		// term times y
		always_comb begin
			a_n      = prev;
			a_n.prod = 64'(prev.term) * 64'(prev.y);
		end

		// divide by the term index through its reciprocal
		always_comb begin
			b_n      = ta_s[g];
			b_n.term = ta_s[g].prod[63:32];
			b_n.prod = 64'(ta_s[g].prod[63:32]) * 64'(RECIP);
		end

		// quotient estimate is at most one low, then accumulate
		always_comb begin
			q0  = tb_s[g].prod[63:32];
			rem = tb_s[g].term - 32'(36'(q0) * 36'(DIVISOR));
			qt  = (rem >= 32'(DIVISOR)) ? q0 + 32'd1 : q0;
			c_n      = tb_s[g];
			c_n.term = qt;
			if (ODD) begin
				c_n.acc = tb_s[g].acc - $signed({3'b000, qt});
			end else begin
				c_n.acc = tb_s[g].acc + $signed({3'b000, qt});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va_s[g] <= 1'b0;
				vb_s[g] <= 1'b0;
				vc_s[g] <= 1'b0;
			end else if (en) begin
				va_s[g] <= prev_v;
				vb_s[g] <= va_s[g];
				vc_s[g] <= vb_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ta_s[g] <= a_n;
				tb_s[g] <= b_n;
				tc_s[g] <= c_n;
			end
		end
	end

	assign out_valid = vc_s[STEPS-1];
	assign out_side  = tc_s[STEPS-1].side;
	assign sum       = tc_s[STEPS-1].acc;

endmodule

// ===== hdl/gaussian_tophat_pdf.sv =====
// gaussian density / top-hat window evaluator, fully pipelined
// Takes one item per clock while the output is not stalled and returns one result per item,
// in order. The pipeline holds two restoring dividers with one quotient bit per stage
// (32 stages for the normalized distance, 39 for the final scaling by 1/sigma) and the
// 14-term exponential series, one stage for the first term and three for each of the
// other thirteen. A stall on the result side freezes the whole pipeline; ready follows
// the output register.
module gaussian_tophat_pdf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  gtp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output gtp_pkg::rsp_t rsp
);
	import gtp_pkg::*;

	typedef struct packed {
		side_t       side;
		logic [30:0] rem;
		logic [31:0] quo;
		logic [2:0]  low;
	} d1_t;

	typedef struct packed {
		side_t       side;
		logic [30:0] rem;
		logic [38:0] quo;
		logic [38:0] num;
	} d2_t;

	logic en;

	// pipeline advances unless a result is held
	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;

	// distance and window tests
	logic signed [32:0] diff;
	logic [31:0]        dist_abs;
	side_t              side_n;

	assign diff     = 33'(req.sample) - 33'(req.center);
	assign dist_abs = diff[32] ? 32'(-diff) : diff[31:0];

	always_comb begin
		side_n        = '0;
		side_n.gauss  = (req.command == CMD_GAUSSIAN);
		side_n.bad    = (req.command == CMD_GAUSSIAN) && (req.spread == '0);
		side_n.hit    = ({1'b0, dist_abs} <= {2'b00, req.spread});
		side_n.far    = ({2'b00, dist_abs} >= {req.spread, 3'b000});
		side_n.spread = req.spread;
	end

	logic        v_s1;
	side_t       side_s1;
	logic [31:0] dist_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_n;
			dist_s1 <= dist_abs;
		end
	end

	// ratio dist / spread in q3.29, one bit per stage
	d1_t  d1_in;
	d1_t  d1_s [DIV1_STEPS];
	logic d1_v_s [DIV1_STEPS];

	always_comb begin
		d1_in      = '0;
		d1_in.side = side_s1;
		d1_in.rem  = 31'(dist_s1[31:3]);
		d1_in.low  = dist_s1[2:0];
	end

	for (genvar j = 0; j < DIV1_STEPS; j++) begin : g_div1
		d1_t         prev;
		logic        prev_v;
		d1_t         nxt;
		logic [31:0] trial;
		logic        ge;

		if (j == 0) begin : g_first
			assign prev   = d1_in;
			assign prev_v = v_s1;
		end else begin : g_next
			assign prev   = d1_s[j-1];
			assign prev_v = d1_v_s[j-1];
		end

		always_comb begin
			trial    = {prev.rem, prev.low[2]};
			ge       = trial >= {1'b0, prev.side.spread};
			nxt      = prev;
			nxt.low  = {prev.low[1:0], 1'b0};
			nxt.rem  = ge ? 31'(trial - {1'b0, prev.side.spread}) : trial[30:0];
			nxt.quo  = {prev.quo[30:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_v_s[j] <= 1'b0;
			end else if (en) begin
				d1_v_s[j] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d1_s[j] <= nxt;
			end
		end
	end

	// square of the ratio
	logic        v_m1;
	side_t       side_m1;
	logic [63:0] sq_m1;

	// scale by log2(e), split into two partial products
	logic        v_m2;
	side_t       side_m2;
	logic [53:0] phi_m2;
	logic [48:0] plo_m2;
	logic [36:0] t_m1;

	// integer and fraction of the base-2 exponent
	logic        v_m3;
	side_t       side_m3;
	logic [31:0] g_m3;
	logic [38:0] u_m2;
	side_t       side_u;

	// fraction back to natural base
	logic        v_m4;
	side_t       side_m4;
	logic [63:0] yp_m4;

	assign t_m1 = sq_m1[63:27];
	assign u_m2 = 39'(phi_m2[53:16]) + 39'(plo_m2[48:32]);

	// integer part of the exponent rides along as the final shift
	always_comb begin
		side_u       = side_m2;
		side_u.shift = u_m2[38:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
		end else if (en) begin
			v_m1 <= d1_v_s[DIV1_STEPS-1];
			v_m2 <= v_m1;
			v_m3 <= v_m2;
			v_m4 <= v_m3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_m1 <= d1_s[DIV1_STEPS-1].side;
			sq_m1   <= 64'(d1_s[DIV1_STEPS-1].quo) * 64'(d1_s[DIV1_STEPS-1].quo);
			side_m2 <= side_m1;
			phi_m2  <= 54'(t_m1[36:16]) * 54'(LOG2E);
			plo_m2  <= 49'(t_m1[15:0]) * 49'(LOG2E);
			side_m3 <= side_u;
			g_m3    <= u_m2[31:0];
			side_m4 <= side_m3;
			yp_m4   <= 64'(g_m3) * 64'(LN2);
		end
	end

	// exponential series
	logic               ex_v;
	side_t              ex_side;
	logic signed [34:0] ex_sum;

	gtp_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_m4),
		.in_side   (side_m4),
		.y         (yp_m4[63:32]),
		.out_valid (ex_v),
		.out_side  (ex_side),
		.sum       (ex_sum)
	);

	// clamp and scale by 1/sqrt(2 pi)
	logic [32:0] mant;
	logic        v_m5;
	side_t       side_m5;
	logic [63:0] m2p_m5;

	assign mant = ex_sum[34] ? 33'd0 : ex_sum[32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m5 <= 1'b0;
		end else if (en) begin
			v_m5 <= ex_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_m5 <= ex_side;
			m2p_m5  <= 64'(mant) * 64'(INV_SQRT_2PI);
		end
	end

	// density mantissa divided by spread, one bit per stage
	d2_t  d2_in;
	d2_t  d2_s [DIV2_STEPS];
	logic d2_v_s [DIV2_STEPS];

	always_comb begin
		d2_in      = '0;
		d2_in.side = side_m5;
		d2_in.num  = {m2p_m5[62:32], 8'h00};
	end

	for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_div2
		d2_t         prev;
		logic        prev_v;
		d2_t         nxt;
		logic [31:0] trial;
		logic        ge;

		if (j == 0) begin : g_first
			assign prev   = d2_in;
			assign prev_v = v_m5;
		end else begin : g_next
			assign prev   = d2_s[j-1];
			assign prev_v = d2_v_s[j-1];
		end

		always_comb begin
			trial    = {prev.rem, prev.num[38]};
			ge       = trial >= {1'b0, prev.side.spread};
			nxt      = prev;
			nxt.num  = {prev.num[37:0], 1'b0};
			nxt.rem  = ge ? 31'(trial - {1'b0, prev.side.spread}) : trial[30:0];
			nxt.quo  = {prev.quo[37:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d2_v_s[j] <= 1'b0;
			end else if (en) begin
				d2_v_s[j] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d2_s[j] <= nxt;
			end
		end
	end

	// exponent shift, saturation and result select
	d2_t         fin;
	logic [38:0] shifted;
	logic [31:0] sat;
	rsp_t        rsp_n;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	assign fin     = d2_s[DIV2_STEPS-1];
	assign shifted = fin.quo >> fin.side.shift;
	assign sat     = (shifted[38:32] != '0) ? DENSITY_MAX : shifted[31:0];

	always_comb begin
		rsp_n = '0;
		if (!fin.side.gauss) begin
			rsp_n.density = fin.side.hit ? ONE_Q24 : '0;
		end else if (fin.side.bad) begin
			rsp_n.bad_width = 1'b1;
		end else if (!fin.side.far) begin
			rsp_n.density = sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= d2_v_s[DIV2_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// zero-width gaussian never reports a density
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_width |-> rsp.density == '0)
		else $error("bad_width item with nonzero density");

	// a held result blocks the input side
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("input accepted while result stalled");

	// top-hat result is either zero or one
	a_tophat_range: assert property (@(posedge clk) disable iff (!arst_n)
		en && d2_v_s[DIV2_STEPS-1] && !fin.side.gauss
		|=> rsp.density == '0 || rsp.density == ONE_Q24)
		else $error("top-hat density out of range");

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the gaussian / top-hat density evaluator
`timescale 1ns / 100ps

module tb;
	import gtp_pkg::*;

	localparam int LATENCY    = 118;
	localparam int IDLE_LIMIT = 4000;
	localparam int N_RANDOM   = 850;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	rsp_t  expected_q[$];
	int    errors = 0;
	int    idle_cycles = 0;
	bit    sending_done = 1'b0;
	bit    long_stall = 1'b0;

	// one directed row: item plus optional typed-in answer
	typedef struct {
		req_t item;
		bit   fixed;
		rsp_t answer;
	} row_t;

	gaussian_tophat_pdf dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #1 clk = ~clk;

	// e^-y in q32 by alternating series
	function automatic logic [63:0] exp_neg(input logic [63:0] y);
		logic signed [65:0] acc;
		logic [63:0] term;
		acc = 66'sd1 <<< 32;
		term = 64'd1 << 32;
		for (int i = 1; i <= TERMS; i++) begin
			term = ((term * y) >> 32) / i;
			if (i % 2 == 1) acc = acc - $signed({2'b0, term});
			else acc = acc + $signed({2'b0, term});
		end
		if (acc < 0) acc = 0;
		return acc[63:0];
	endfunction

	// predicted density and flag for one item
	function automatic rsp_t predict_density(input req_t it);
		rsp_t o;
		logic signed [33:0] lo, hi, d;
		logic [63:0] a, s, qi, r, t, u, k, g, y, m, m2;
		logic [127:0] q;
		o = '0;
		s = it.spread;
		if (it.command == CMD_TOPHAT) begin
			lo = it.center - $signed({3'b0, it.spread});
			hi = it.center + $signed({3'b0, it.spread});
			if (it.sample >= lo && it.sample <= hi) o.density = ONE_Q24;
		end else if (s == 0) begin
			o.bad_width = 1'b1;
		end else begin
			d = it.sample - it.center;
			a = (d < 0) ? -d : d;
			qi = a / s;
			if (qi < 8) begin
				r = (qi << 29) | (((a % s) << 29) / s);
				t = (r * r) >> 27;
				u = (((t >> 16) * LOG2E) >> 16) + (((t & 64'hFFFF) * LOG2E) >> 32);
				k = u >> 32;
				g = u & 64'hFFFF_FFFF;
				y = (g * LN2) >> 32;
				m = exp_neg(y);
				m2 = (m * INV_SQRT_2PI) >> 32;
				q = ({64'd0, m2} << 8) / s;
				if (k < 64) begin
					q = q >> k;
					o.density = (q > DENSITY_MAX) ? DENSITY_MAX : q[31:0];
				end
			end
		end
		return o;
	endfunction

	task automatic report(input string what, input rsp_t got, input rsp_t want);
		errors++;
		$display("mismatch %s: got %h/%b want %h/%b", what, got.density, got.bad_width,
			want.density, want.bad_width);
	endtask

	// offer one item, hold until accepted, record its expectation
	task automatic send_item(input req_t it, input bit fixed, input rsp_t answer);
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		expected_q.push_back(fixed ? answer : predict_density(it));
	endtask

	function automatic req_t random_item();
		req_t it;
		it.command = 1'($urandom_range(0, 1));
		it.center = $urandom;
		it.sample = $urandom;
		case ($urandom_range(0, 5))
			0: it.spread = 31'($urandom);
			1: it.spread = 31'($urandom_range(0, 255));
			default: it.spread = 31'($urandom_range(1, 32'h0008_0000));
		endcase
		// mostly keep the sample near the mean so the density is nonzero
		if ($urandom_range(0, 4) != 0)
			it.sample = it.center + $signed($urandom_range(0, 8 * it.spread + 2))
				- $signed(4 * it.spread + 1);
		return it;
	endfunction

	// sender: directed table then random bursts
	initial begin
		row_t rows[$];
		row_t rw;
		rsp_t zero, one, bad;
		int burst;
		zero = '0;
		one = '{density: ONE_Q24, bad_width: 1'b0};
		bad = '{density: 32'd0, bad_width: 1'b1};
		rows.push_back('{'{CMD_TOPHAT, 32'sd0, 31'd0, 32'sd0}, 1, one});
		rows.push_back('{'{CMD_TOPHAT, 32'sd0, 31'd0, 32'sd1}, 1, zero});
		rows.push_back('{'{CMD_TOPHAT, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh8000_0000}, 1, zero});
		rows.push_back('{'{CMD_TOPHAT, 32'sh8000_0000, 31'h7FFF_FFFF,
			32'sh7FFF_FFFF}, 1, zero});
		rows.push_back('{'{CMD_TOPHAT, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh0000_0000}, 1, one});
		rows.push_back('{'{CMD_TOPHAT, 32'sd100, 31'd50, 32'sd150}, 1, one});
		rows.push_back('{'{CMD_TOPHAT, 32'sd100, 31'd50, 32'sd50}, 1, one});
		rows.push_back('{'{CMD_TOPHAT, 32'sd100, 31'd50, 32'sd151}, 1, zero});
		rows.push_back('{'{CMD_TOPHAT, 32'sd100, 31'd50, 32'sd49}, 1, zero});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sd5, 31'd0, 32'sd5}, 1, bad});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sh8000_0000, 31'd0,
			32'sh7FFF_FFFF}, 1, bad});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sd0, 31'd65536, 32'sd0}, 0, zero});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sd0, 31'd65536, 32'sd65536}, 0, zero});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sd0, 31'd65536, -32'sd500000}, 1, zero});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sd0, 31'd65536, 32'sd524288}, 1, zero});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sd0, 31'd65536, 32'sd524287}, 0, zero});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sd0, 31'd1, 32'sd0}, 1,
			'{density: DENSITY_MAX, bad_width: 1'b0}});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sd0, 31'd1, 32'sd1}, 0, zero});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sh8000_0000, 31'h7FFF_FFFF,
			32'sh7FFF_FFFF}, 0, zero});
		rows.push_back('{'{CMD_GAUSSIAN, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh8000_0000}, 0, zero});
		rows.push_back('{'{CMD_GAUSSIAN, -32'sd1, 31'h4000_0000, 32'sd1}, 0, zero});
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			rw = rows[i];
			send_item(rw.item, rw.fixed, rw.answer);
		end
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
				send_item(random_item(), 1'b0, zero);
			// optional gap between bursts
			if ($urandom_range(0, 2) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		req_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// receiver: own stall pattern, one long hold-off early on
	initial begin
		int mode;
		@(posedge arst_n);
		repeat (5) @(posedge clk);
		rsp_ready <= 1'b0;
		long_stall = 1'b1;
		repeat (400) @(posedge clk);
		long_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 60)) begin
				rsp_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
				@(posedge clk);
			end
		end
	end

	// check results and run the watchdog
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || long_stall)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected item", rsp, '0);
				end else begin
					want = expected_q.pop_front();
					if (rsp.density !== want.density) report("density", rsp, want);
					if (rsp.bad_width !== want.bad_width) report("bad_width", rsp, want);
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// end of run
	initial begin
		wait (sending_done);
		wait (expected_q.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/gtp_pkg.sv
hdl/gtp_exp.sv
hdl/gaussian_tophat_pdf.sv
tb/sv/tb.sv
